### rtl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types, constants and the ones'-complement adder for the go-back-N
// receiver.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int GBN_MAX_DATAGRAM_WORDS = 8192;
  localparam logic [15:0] GBN_ACK_DELAY_RESET = 16'd100;
  localparam logic [15:0] GBN_SUM_GOOD = 16'hffff;
  localparam logic [16:0] GBN_TICK_MAX = 17'h1ffff;
  localparam logic [15:0] GBN_SEQ_START = 16'd1;
  localparam logic [7:0] GBN_FLAG_SYN = 8'h10;
  localparam logic [7:0] GBN_FLAG_FEND = 8'h02;

  typedef enum logic {
    OP_WORD = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_SYN     = 2'd0,
    KIND_DELAYED = 2'd1,
    KIND_FEND    = 2'd2
  } ack_kind_t;

  typedef struct packed {
    opcode_t     op;
    logic [15:0] data_word;
    logic        last_word;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] seq;
    ack_kind_t   kind;
  } ack_res_t;

  // end-around-carry add
  function automatic logic [15:0] oc_add(input logic [15:0] s, input logic [15:0] w);
    logic [16:0] t;
    t = {1'b0, s} + {1'b0, w};
    return t[15:0] + {15'd0, t[16]};
  endfunction

endpackage

### rtl/gbn_receiver_delayed_ack.sv
// ----------------------------------------------------------------------------
// gbn_receiver_delayed_ack
// Go-back-N receiver: checks datagram sums, tracks the expected sequence and
// issues SYN replies, delayed cumulative ACKs and file-end ACKs.
// ----------------------------------------------------------------------------
//  channel  dir  tdata           tuser        tlast
//  s_*      in   data_word[15:0] opcode[0]    last_word
//  m_*      out  ack_seq[15:0]   ack_kind[1:0] -
//  cfg_*    in   ack_delay_ticks -            -
//
// One word accepted per cycle unless the output stalls; a result passes through
// the input register, then the result register.
// The input stage holds only when it has a result and the result register is
// still full, so s_tready falls only under output back-pressure.
// Synchronous reset returns all sequence, timer and datagram state to its start values.
module gbn_receiver_delayed_ack import gbn_pkg::*; #(
  parameter int MAX_DATAGRAM_WORDS = GBN_MAX_DATAGRAM_WORDS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // data_word[15:0]
  input  logic [0:0]  s_tuser,   // opcode[0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // ack_seq[15:0]
  output logic [1:0]  m_tuser,   // ack_kind[1:0]
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [15:0] ack_delay;
  logic        st_valid;
  item_t       st_item;
  logic        out_valid;
  logic        st_adv;
  ack_res_t    res;

  assign st_adv   = st_valid && (!res.valid || !out_valid || m_tready);
  assign s_tready = !st_valid || st_adv;
  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_delay <= GBN_ACK_DELAY_RESET;
    end else if (cfg_wr_en) begin
      ack_delay <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (s_tready) begin
      st_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      st_item.op        <= opcode_t'(s_tuser[0]);
      st_item.data_word <= s_tdata;
      st_item.last_word <= s_tlast;
    end
  end

  gbn_rx_core #(
    .MAX_DATAGRAM_WORDS(MAX_DATAGRAM_WORDS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (st_adv),
    .item     (st_item),
    .ack_delay(ack_delay),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st_adv && res.valid) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_adv && res.valid) begin
      m_tdata <= res.seq;
      m_tuser <= res.kind;
    end
  end

endmodule

### rtl/gbn_rx_core.sv
// ----------------------------------------------------------------------------
// gbn_rx_core
// Per-word datagram checking, sequence tracking and delayed-ACK timer.
// ----------------------------------------------------------------------------
module gbn_rx_core import gbn_pkg::*; #(
  parameter int MAX_DATAGRAM_WORDS = GBN_MAX_DATAGRAM_WORDS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  item_t       item,
  input  logic [15:0] ack_delay,
  output ack_res_t    res
);

  localparam int CNT_W = $clog2(MAX_DATAGRAM_WORDS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DATAGRAM_WORDS);

  logic [15:0]      expected_seq, expected_seq_next;
  logic             ack_pending, ack_pending_next;
  logic [16:0]      elapsed_ticks, elapsed_ticks_next;
  logic [CNT_W-1:0] word_count, word_count_next;
  logic [15:0]      running_sum, running_sum_next;
  logic [14:0]      half_len, half_len_next;
  logic [15:0]      seq_field, seq_field_next;
  logic [7:0]       flag_byte, flag_byte_next;
  logic [15:0]      head0, head0_next;
  logic [15:0]      head1, head1_next;

  logic [14:0] w_half;
  logic [15:0] w2_sum;

  always_comb begin
    expected_seq_next  = expected_seq;
    ack_pending_next   = ack_pending;
    elapsed_ticks_next = elapsed_ticks;
    word_count_next    = word_count;
    running_sum_next   = running_sum;
    half_len_next      = half_len;
    seq_field_next     = seq_field;
    flag_byte_next     = flag_byte;
    head0_next         = head0;
    head1_next         = head1;
    res.valid          = 1'b0;
    res.seq            = 16'd0;
    res.kind           = KIND_SYN;

    w_half = item.data_word[15:1];
    w2_sum = 16'd0;
    if (w_half > 15'd0) w2_sum = oc_add(w2_sum, head0);
    if (w_half > 15'd1) w2_sum = oc_add(w2_sum, head1);
    if (w_half > 15'd2) w2_sum = oc_add(w2_sum, item.data_word);

    if (item.op == OP_TICK) begin
      if (elapsed_ticks < GBN_TICK_MAX) elapsed_ticks_next = elapsed_ticks + 17'd1;
      if (ack_pending && (elapsed_ticks_next > {1'b0, ack_delay})) begin
        ack_pending_next = 1'b0;
        res.valid        = 1'b1;
        res.seq          = expected_seq - 16'd1;
        res.kind         = KIND_DELAYED;
      end
    end else begin
      // words beyond the limit are neither counted nor summed
      if (word_count < CNT_MAX) begin
        case (word_count)
          CNT_W'(0): head0_next = item.data_word;
          CNT_W'(1): head1_next = item.data_word;
          CNT_W'(2): begin
            half_len_next    = w_half;
            running_sum_next = w2_sum;
          end
          default: begin
            if (word_count == CNT_W'(4)) seq_field_next = item.data_word;
            if (word_count == CNT_W'(7)) flag_byte_next = item.data_word[7:0];
            if ({{(17-CNT_W){1'b0}}, word_count} < {2'b00, half_len})
              running_sum_next = oc_add(running_sum, item.data_word);
          end
        endcase
        word_count_next = word_count + CNT_W'(1);
      end

      if (item.last_word) begin
        if ((running_sum_next == GBN_SUM_GOOD) && (word_count_next > CNT_W'(2))) begin
          if ((flag_byte_next & GBN_FLAG_SYN) != 8'd0) begin
            res.valid = 1'b1;
            res.seq   = 16'd0;
            res.kind  = KIND_SYN;
          end else if (seq_field_next == expected_seq) begin
            expected_seq_next  = expected_seq + 16'd1;
            elapsed_ticks_next = 17'd0;
            ack_pending_next   = 1'b1;
            if ((flag_byte_next & GBN_FLAG_FEND) != 8'd0) begin
              res.valid         = 1'b1;
              res.seq           = seq_field_next;
              res.kind          = KIND_FEND;
              expected_seq_next = GBN_SEQ_START;
              ack_pending_next  = 1'b0;
            end
          end
        end
        word_count_next  = '0;
        running_sum_next = 16'd0;
        half_len_next    = 15'd0;
        seq_field_next   = 16'd0;
        flag_byte_next   = 8'd0;
        head0_next       = 16'd0;
        head1_next       = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_seq  <= GBN_SEQ_START;
      ack_pending   <= 1'b0;
      elapsed_ticks <= 17'd0;
      word_count    <= '0;
      running_sum   <= 16'd0;
      half_len      <= 15'd0;
      seq_field     <= 16'd0;
      flag_byte     <= 8'd0;
      head0         <= 16'd0;
      head1         <= 16'd0;
    end else if (fire) begin
      expected_seq  <= expected_seq_next;
      ack_pending   <= ack_pending_next;
      elapsed_ticks <= elapsed_ticks_next;
      word_count    <= word_count_next;
      running_sum   <= running_sum_next;
      half_len      <= half_len_next;
      seq_field     <= seq_field_next;
      flag_byte     <= flag_byte_next;
      head0         <= head0_next;
      head1         <= head1_next;
    end
  end

endmodule

### dv/tb_gbn_receiver_delayed_ack.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for gbn_receiver_delayed_ack. Streams datagram words
// and timer ticks into the receiver, predicts every ACK it should send, and
// compares each ACK on the output stream against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import gbn_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [15:0] seq;
    ack_kind_t   kind;
  } ack_t;

  // Shadow of the receiver state; queues up the ACKs each accepted word causes.
  class ack_tracker;
    logic [15:0] ack_delay;
    logic [15:0] exp_seq;
    bit          ack_armed;
    logic [16:0] tick_count;
    int          word_idx;
    logic [15:0] csum;
    logic [15:0] len_bytes;
    logic [15:0] seq_word;
    logic [15:0] head0;
    logic [15:0] head1;
    logic [7:0]  flags;
    ack_t        acks_due[$];
    int          errors;

    function new();
      ack_delay  = GBN_ACK_DELAY_RESET;
      exp_seq    = GBN_SEQ_START;
      ack_armed  = 1'b0;
      tick_count = '0;
      errors     = 0;
      clear_dg();
    endfunction

    function void clear_dg();
      word_idx  = 0;
      csum      = '0;
      len_bytes = '0;
      seq_word  = '0;
      head0     = '0;
      head1     = '0;
      flags     = '0;
    endfunction

    static function logic [15:0] fold_add(logic [15:0] a, logic [15:0] b);
      logic [16:0] t;
      t = {1'b0, a} + {1'b0, b};
      if (t[16]) t = {1'b0, t[15:0]} + 17'd1;
      return t[15:0];
    endfunction

    function void push_ack(logic [15:0] s, ack_kind_t k);
      ack_t a;
      a.seq  = s;
      a.kind = k;
      acks_due.push_back(a);
    endfunction

    function void take_word(opcode_t op, logic [15:0] w, logic last);
      int half;
      if (op == OP_TICK) begin
        if (tick_count != GBN_TICK_MAX) tick_count = tick_count + 17'd1;
        if (ack_armed && tick_count > {1'b0, ack_delay}) begin
          ack_armed = 1'b0;
          push_ack(exp_seq - 16'd1, KIND_DELAYED);
        end
        return;
      end
      // words past the size limit are neither counted nor summed
      if (word_idx < GBN_MAX_DATAGRAM_WORDS) begin
        half = len_bytes >> 1;
        case (word_idx)
          0: head0 = w;
          1: head1 = w;
          2: begin
            // length known now: fold in the held header words
            len_bytes = w;
            half = w >> 1;
            csum = '0;
            if (half > 0) csum = fold_add(csum, head0);
            if (half > 1) csum = fold_add(csum, head1);
            if (half > 2) csum = fold_add(csum, w);
          end
          default: begin
            if (word_idx == 4) seq_word = w;
            if (word_idx == 7) flags = w[7:0];
            if (word_idx < half) csum = fold_add(csum, w);
          end
        endcase
        word_idx++;
      end
      if (!last) return;
      if (csum == GBN_SUM_GOOD && word_idx > 2) begin
        if ((flags & GBN_FLAG_SYN) != 0) begin
          push_ack(16'd0, KIND_SYN);
        end else if (seq_word == exp_seq) begin
          exp_seq    = exp_seq + 16'd1;
          tick_count = '0;
          ack_armed  = 1'b1;
          if ((flags & GBN_FLAG_FEND) != 0) begin
            push_ack(seq_word, KIND_FEND);
            exp_seq   = GBN_SEQ_START;
            ack_armed = 1'b0;
          end
        end
      end
      clear_dg();
    endfunction

    function void match_ack(logic [15:0] seq, logic [1:0] kind);
      ack_t e;
      if (acks_due.size() == 0) begin
        errors++;
        $display("%0t: ACK with none due, got seq %h kind %0d", $time, seq, kind);
        return;
      end
      e = acks_due.pop_front();
      if (seq !== e.seq) begin
        errors++;
        $display("%0t: ack_seq expected %h got %h", $time, e.seq, seq);
      end
      if (kind !== e.kind) begin
        errors++;
        $display("%0t: ack_kind expected %0d got %0d", $time, e.kind, kind);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // data_word[15:0]
  logic [0:0]  s_tuser = '0;   // opcode[0]
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // ack_seq[15:0]
  logic [1:0]  m_tuser;        // ack_kind[1:0]
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  ack_tracker tracker = new();

  int src_pct   = 0;
  int dst_pct   = 0;
  int hold_left = 0;
  int n_sent    = 0;
  int cycles    = 0;

  gbn_receiver_delayed_ack u_dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #2 clk = ~clk;

  // ACK sink: long hold-off when requested, else random stalls
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= dst_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.match_ack(m_tdata, m_tuser);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[gbn_receiver_delayed_ack] ERROR");
      $finish;
    end
  end

  task automatic send_item(opcode_t op, logic [15:0] d, logic l);
    while (src_pct > 0 && $urandom_range(99) < src_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= d;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
    tracker.take_word(op, d, l);
    n_sent++;
  endtask

  task automatic send_ticks(int k);
    repeat (k) send_item(OP_TICK, 16'($urandom), 1'($urandom));
  endtask

  // wait for every ACK due, then let the pipeline settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (tracker.acks_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_delay(logic [15:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.ack_delay = v;
  endtask

  function automatic logic [7:0] pick_flags(bit syn, bit fend);
    logic [7:0] f;
    f = 8'($urandom) & ~(GBN_FLAG_SYN | GBN_FLAG_FEND);
    if (syn) f = f | GBN_FLAG_SYN;
    if (fend) f = f | GBN_FLAG_FEND;
    return f;
  endfunction

  // Builds n words with length, sequence and flag fields in place; word 0
  // carries the checksum, one bit flipped when a bad sum is wanted.
  task automatic send_datagram(int n, logic [15:0] seq, logic [7:0] flg,
                               logic [15:0] lenb, bit good);
    logic [15:0] w[$];
    logic [15:0] s;
    int lim;
    for (int i = 0; i < n; i++) w.push_back(16'($urandom));
    if (n > 2) w[2] = lenb;
    if (n > 4) w[4] = seq;
    if (n > 7) w[7] = {w[7][15:8], flg};
    lim = lenb >> 1;
    if (lim > n) lim = n;
    if (lim > GBN_MAX_DATAGRAM_WORDS) lim = GBN_MAX_DATAGRAM_WORDS;
    if (lim > 0) begin
      s = '0;
      for (int i = 1; i < lim; i++) s = ack_tracker::fold_add(s, w[i]);
      w[0] = ~s;
      if (!good) w[0] = w[0] ^ (16'd1 << $urandom_range(15));
    end
    for (int i = 0; i < n; i++) begin
      // the odd tick mid-datagram must not disturb assembly
      if ($urandom_range(99) < 4) send_ticks(1);
      send_item(OP_WORD, w[i], i == n - 1);
    end
  endtask

  task automatic random_traffic(int quota);
    int stop;
    int r;
    int n;
    int cap;
    logic [15:0] lenb;
    stop = n_sent + quota;
    while (n_sent < stop) begin
      r = $urandom_range(99);
      n = $urandom_range(8, 14);
      lenb = 16'(2 * n);
      case ($urandom_range(9))
        0: lenb = lenb + 16'($urandom_range(1, 40));
        1: lenb = 16'($urandom_range(2, 2 * n - 1));
        2: lenb = lenb + 16'd1;
        default: ;
      endcase
      if (r < 50) begin
        send_datagram(n, tracker.exp_seq,
                      pick_flags($urandom_range(99) < 8, $urandom_range(99) < 15), lenb, 1);
      end else if (r < 60) begin
        send_datagram(n, tracker.exp_seq + 16'($urandom_range(1, 65535)),
                      pick_flags(0, $urandom_range(1)), lenb, 1);
      end else if (r < 68) begin
        send_datagram(n, tracker.exp_seq,
                      pick_flags($urandom_range(1), $urandom_range(1)), lenb, 0);
      end else if (r < 76) begin
        // short datagrams, arbitrary lengths
        n = $urandom_range(1, 7);
        lenb = 16'($urandom_range(0, 2 * n + 6));
        send_datagram(n, tracker.exp_seq, 8'h00, lenb, $urandom_range(1));
      end else begin
        cap = (tracker.ack_delay > 22) ? 24 : tracker.ack_delay + 2;
        send_ticks($urandom_range(1, cap));
      end
    end
  endtask

  task automatic traffic_phase(logic [15:0] delay_v, int sp, int dp, int quota);
    drain();
    write_delay(delay_v);
    src_pct = sp;
    dst_pct = dp;
    random_traffic(quota);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // SYN wins over file end and sequence
    send_datagram(8, 16'hffff, 8'hff, 16'd16, 1);
    // two words only: length never seen
    send_item(OP_WORD, 16'hffff, 1'b0);
    send_item(OP_WORD, 16'hffff, 1'b1);
    send_item(OP_TICK, 16'hffff, 1'b1);
    send_item(OP_TICK, 16'h0000, 1'b0);
    send_datagram(8, GBN_SEQ_START, GBN_FLAG_FEND, 16'd16, 1);
    // zero length: empty sum
    send_datagram(3, 16'd0, 8'h00, 16'd0, 1);

    traffic_phase(16'd3, 0, 0, 180);
    traffic_phase(16'd0, 48, 0, 180);
    traffic_phase(16'd1, 0, 48, 180);
    traffic_phase(16'hffff, 15, 15, 180);

    // sink holds off while SYN replies pile up behind it
    drain();
    write_delay(16'd20);
    src_pct = 0;
    dst_pct = 0;
    hold_left = 400;
    repeat (6) send_datagram(8, 16'($urandom), pick_flags(1, 0), 16'd16, 1);
    random_traffic(180);

    // long datagram, length field well past the words received
    drain();
    write_delay(16'd2);
    src_pct = 48;
    dst_pct = 48;
    send_datagram(40, tracker.exp_seq, pick_flags(0, 0), 16'hffff, 1);
    send_ticks(4);
    drain();

    if (tracker.errors == 0) begin
      $display("[gbn_receiver_delayed_ack] OK");
    end else begin
      $display("[gbn_receiver_delayed_ack] ERROR");
    end
    $finish;
  end

endmodule
